@@ hw/rtl/render_variant_cache_lookup_macros.svh @@
// Assertion macros for the checker of the variant cache.
// Each expects signals named clk and rst_n in the scope where it is used.
`ifndef RENDER_VARIANT_CACHE_LOOKUP_MACROS_SVH
`define RENDER_VARIANT_CACHE_LOOKUP_MACROS_SVH

// Same-cycle implication, disabled in reset
`define RVC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("variant cache check failed");

// Next-cycle implication, disabled in reset
`define RVC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("variant cache check failed");

`endif

@@ hw/rtl/rvc_pkg.sv @@
`timescale 1ns / 1ps

package rvc_pkg;

    // Slot count and derived widths
    localparam int SLOT_COUNT = 8;
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] SLOT_LAST = IDX_W'(SLOT_COUNT - 1);

    // Field widths
    localparam int KIND_W = 2;
    localparam int DEPTH_MODE_W = 3;
    localparam int SLOT_FIELD_W = 3;

    // Entry layout: key above use count
    localparam int KEY_W = 11;
    localparam int USES_W = 32;
    localparam int ENTRY_W = KEY_W + USES_W;
    localparam logic [KEY_W-1:0] KEY_VALID_BIT = KEY_W'(1 << 7);
    localparam logic [USES_W-1:0] USES_MAX = '1;

    // Controller to datapath
    typedef struct packed {
        logic             start;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             scan;
        logic             commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic hit;
        logic last;
        logic out_free;
    } status_t;

    // Pack the render settings into a slot key; bit 7 marks a used key
    function automatic logic [KEY_W-1:0] pack_key(
        input logic [KIND_W-1:0]       render_kind,
        input logic                    color_key_on,
        input logic                    intensity_on,
        input logic                    perspective_on,
        input logic                    writes_color,
        input logic                    writes_depth,
        input logic [DEPTH_MODE_W-1:0] depth_mode
    );
        logic [KEY_W-1:0] key;
        key = {depth_mode, 1'b0, writes_depth, writes_color, perspective_on,
               intensity_on, color_key_on, render_kind};
        return key | KEY_VALID_BIT;
    endfunction

    // Report the low bits of a slot number in the result field
    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_FIELD_W-1:0] wide;
        wide = {{SLOT_FIELD_W{1'b0}}, idx};
        return wide[SLOT_FIELD_W-1:0];
    endfunction

endpackage

@@ hw/rtl/rvc_ifs.sv @@
`timescale 1ns / 1ps

// Lookup channel: one set of render settings per transfer
interface rvc_lookup_if;
    logic                            valid;
    logic                            ready;
    logic [rvc_pkg::KIND_W-1:0]       render_kind;
    logic                            color_key_on;
    logic                            intensity_on;
    logic                            perspective_on;
    logic                            writes_color;
    logic                            writes_depth;
    logic [rvc_pkg::DEPTH_MODE_W-1:0] depth_mode;

    modport source (
        output valid, render_kind, color_key_on, intensity_on, perspective_on,
               writes_color, writes_depth, depth_mode,
        input  ready
    );
    modport sink (
        input  valid, render_kind, color_key_on, intensity_on, perspective_on,
               writes_color, writes_depth, depth_mode,
        output ready
    );
endinterface

// Result channel: slot number and miss flags per transfer
interface rvc_result_if;
    logic                            valid;
    logic                            ready;
    logic [rvc_pkg::SLOT_FIELD_W-1:0] slot_index;
    logic                            miss;
    logic                            evicted;

    modport source (
        output valid, slot_index, miss, evicted,
        input  ready
    );
    modport sink (
        input  valid, slot_index, miss, evicted,
        output ready
    );
endinterface

@@ hw/rtl/rvc_ctrl.sv @@
`timescale 1ns / 1ps

module rvc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             lookup_valid,
    output logic             lookup_ready,
    input  rvc_pkg::status_t status,
    output rvc_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } state_t;

    state_t                    state_reg;
    logic [rvc_pkg::IDX_W-1:0] cnt_reg;
    logic                      issue_done_reg;

    // Decode commands from state
    assign lookup_ready = (state_reg == ST_IDLE);
    assign cmd.start    = lookup_ready && lookup_valid;
    assign cmd.scan     = (state_reg == ST_SCAN);
    assign cmd.rd_en    = cmd.scan && !issue_done_reg;
    assign cmd.rd_addr  = cnt_reg;
    assign cmd.commit   = (state_reg == ST_WRITE) && status.out_free;

    // Sequence: accept, scan slots one per cycle, commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            issue_done_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.start)
                    begin
                        state_reg      <= ST_SCAN;
                        cnt_reg        <= '0;
                        issue_done_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    if (cmd.rd_en)
                    begin
                        if (cnt_reg == rvc_pkg::SLOT_LAST)
                            issue_done_reg <= 1'b1;
                        else
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (status.hit || status.last)
                        state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    if (cmd.commit)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/rvc_datapath.sv @@
`timescale 1ns / 1ps

module rvc_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [rvc_pkg::KEY_W-1:0]        key,
    input  rvc_pkg::cmd_t                    cmd,
    output rvc_pkg::status_t                 status,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [rvc_pkg::SLOT_FIELD_W-1:0] slot_index,
    output logic                             miss,
    output logic                             evicted
);

    localparam int N = rvc_pkg::SLOT_COUNT;
    localparam int IW = rvc_pkg::IDX_W;
    localparam int KW = rvc_pkg::KEY_W;
    localparam int UW = rvc_pkg::USES_W;
    localparam int EW = rvc_pkg::ENTRY_W;

    // Slot entries: key and use count, no reset
    logic [EW-1:0] entry_mem [N];
    logic [EW-1:0] rd_data_reg;

    logic          eval_vld_reg;
    logic [IW-1:0] eval_idx_reg;
    logic [KW-1:0] key_reg;

    // Per-slot flags: key written, use count live since last clear
    logic [N-1:0]  key_valid_reg;
    logic [N-1:0]  key_valid_next;
    logic [N-1:0]  uses_live_reg;
    logic [N-1:0]  uses_live_next;

    // Scan trackers
    logic          hit_found_reg;
    logic [IW-1:0] hit_idx_reg;
    logic [UW-1:0] hit_uses_reg;
    logic          empty_found_reg;
    logic [IW-1:0] empty_idx_reg;
    logic [UW-1:0] best_reg;
    logic [IW-1:0] best_idx_reg;

    // Result register
    logic                             out_valid_reg;
    logic [rvc_pkg::SLOT_FIELD_W-1:0] out_slot_reg;
    logic                             out_miss_reg;
    logic                             out_evict_reg;

    logic [KW-1:0] eval_key;
    logic [UW-1:0] eval_uses;
    logic          eval_slot_used;
    logic          eval_match;
    logic [IW-1:0] dest_idx;
    logic [N-1:0]  dest_onehot;
    logic [UW-1:0] wr_uses;

    // Evaluate the slot read last cycle
    assign eval_key       = rd_data_reg[EW-1 -: KW];
    assign eval_slot_used = key_valid_reg[eval_idx_reg];
    assign eval_uses      = uses_live_reg[eval_idx_reg] ? rd_data_reg[UW-1:0] : '0;
    assign eval_match     = eval_vld_reg && eval_slot_used && (eval_key == key_reg);

    assign status.hit      = eval_match;
    assign status.last     = eval_vld_reg && (eval_idx_reg == rvc_pkg::SLOT_LAST);
    assign status.out_free = !out_valid_reg || result_ready;

    // Pick the destination: hit slot, highest empty slot, or least-used slot
    always_comb
    begin
        if (hit_found_reg)
            dest_idx = hit_idx_reg;
        else if (empty_found_reg)
            dest_idx = empty_idx_reg;
        else
            dest_idx = best_idx_reg;
    end

    assign dest_onehot = {{(N-1){1'b0}}, 1'b1} << dest_idx;

    // Saturating count on a hit, a fresh count of one on a miss
    always_comb
    begin
        if (!hit_found_reg)
            wr_uses = UW'(1);
        else if (hit_uses_reg == rvc_pkg::USES_MAX)
            wr_uses = hit_uses_reg;
        else
            wr_uses = hit_uses_reg + UW'(1);
    end

    // Flag updates on commit; an eviction clears every other count
    always_comb
    begin
        key_valid_next = key_valid_reg;
        uses_live_next = uses_live_reg;
        if (cmd.commit)
        begin
            key_valid_next = key_valid_reg | dest_onehot;
            if (hit_found_reg || empty_found_reg)
                uses_live_next = uses_live_reg | dest_onehot;
            else
                uses_live_next = dest_onehot;
        end
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
            entry_mem[dest_idx] <= {key_reg, wr_uses};
        if (cmd.rd_en)
            rd_data_reg <= entry_mem[cmd.rd_addr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
            key_reg <= key;
        if (cmd.rd_en)
            eval_idx_reg <= cmd.rd_addr;
        if (cmd.commit)
        begin
            out_slot_reg  <= rvc_pkg::slot_field(dest_idx);
            out_miss_reg  <= !hit_found_reg;
            out_evict_reg <= !hit_found_reg && !empty_found_reg;
        end
    end

    // Control registers and scan trackers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_vld_reg    <= 1'b0;
            key_valid_reg   <= '0;
            uses_live_reg   <= '0;
            hit_found_reg   <= 1'b0;
            hit_idx_reg     <= '0;
            hit_uses_reg    <= '0;
            empty_found_reg <= 1'b0;
            empty_idx_reg   <= '0;
            best_reg        <= rvc_pkg::USES_MAX;
            best_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            eval_vld_reg  <= cmd.rd_en;
            key_valid_reg <= key_valid_next;
            uses_live_reg <= uses_live_next;

            if (cmd.start)
            begin
                hit_found_reg   <= 1'b0;
                empty_found_reg <= 1'b0;
                best_reg        <= rvc_pkg::USES_MAX;
                best_idx_reg    <= '0;
            end
            else if (cmd.scan && eval_vld_reg)
            begin
                if (eval_match)
                begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= eval_idx_reg;
                    hit_uses_reg  <= eval_uses;
                end
                else
                begin
                    // Later empty slots win
                    if (!eval_slot_used)
                    begin
                        empty_found_reg <= 1'b1;
                        empty_idx_reg   <= eval_idx_reg;
                    end
                    // Strict compare keeps the first minimum
                    if (eval_uses < best_reg)
                    begin
                        best_reg     <= eval_uses;
                        best_idx_reg <= eval_idx_reg;
                    end
                end
            end

            // Hold the result until its transfer
            if (cmd.commit)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_valid = out_valid_reg;
    assign slot_index   = out_slot_reg;
    assign miss         = out_miss_reg;
    assign evicted      = out_evict_reg;

endmodule

@@ hw/rtl/render_variant_cache_lookup.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Transfer when    Payload
// lookup   in   valid && ready   render_kind, five flags, depth_mode
// result   out  valid && ready   slot_index, miss, evicted
//
// A miss scans all SLOT_COUNT slots (eight here); a hit in slot s ends the
// scan after slot s. The scan reads one slot per cycle through
// the single read port of the entry memory. One lookup scans at a time.
// Reset clears the per-slot valid and live-count flags at once; no clearing pass.
// A stalled result stays in its output register; the next lookup is taken
// meanwhile, and its commit waits until that register is free.

module render_variant_cache_lookup (
    input logic        clk,
    input logic        rst_n,
    rvc_lookup_if.sink lookup,
    rvc_result_if.source result
);

    rvc_pkg::cmd_t                cmd;
    rvc_pkg::status_t             status;
    logic [rvc_pkg::KEY_W-1:0]    lookup_key;

    // Pack the settings into a key
    assign lookup_key = rvc_pkg::pack_key(lookup.render_kind, lookup.color_key_on,
                                          lookup.intensity_on, lookup.perspective_on,
                                          lookup.writes_color, lookup.writes_depth,
                                          lookup.depth_mode);

    rvc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookup_valid (lookup.valid),
        .lookup_ready (lookup.ready),
        .status       (status),
        .cmd          (cmd)
    );

    rvc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .key          (lookup_key),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .slot_index   (result.slot_index),
        .miss         (result.miss),
        .evicted      (result.evicted)
    );

endmodule

@@ hw/rtl/rvc_checker.sv @@
`timescale 1ns / 1ps
`include "render_variant_cache_lookup_macros.svh"

module rvc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             lookup_valid,
    input logic                             lookup_ready,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic [rvc_pkg::SLOT_FIELD_W-1:0] slot_index,
    input logic                             miss,
    input logic                             evicted
);

    logic [rvc_pkg::SLOT_FIELD_W+1:0] payload;

    assign payload = {slot_index, miss, evicted};

    // A stalled result stays up
    `RVC_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid)

    // A stalled result keeps its payload
    `RVC_ASSERT_NEXT(a_payload_holds, result_valid && !result_ready, $stable(payload))

    // One lookup at a time: no transfer right after a transfer
    `RVC_ASSERT_NEXT(a_one_in_flight, lookup_valid && lookup_ready, !lookup_ready)

    // A new result only comes while the lookup side is busy
    `RVC_ASSERT_NOW(a_result_from_scan, $rose(result_valid), !$past(lookup_ready))

endmodule

bind render_variant_cache_lookup rvc_checker u_rvc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .lookup_valid (lookup.valid),
    .lookup_ready (lookup.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .slot_index   (result.slot_index),
    .miss         (result.miss),
    .evicted      (result.evicted)
);
